/* rtl/core/sha_pkg.sv */
// ============================================================================
// sha_pkg
// Shared types, constants and helper functions for the SHA-256 stream hasher.
// ============================================================================
`default_nettype none

package sha_pkg;

    // input item: func 0 absorbs data_byte, func 1 finishes the message
    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } in_item_t;

    // result item: one digest word
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    localparam logic FUNC_ABSORB = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    localparam int BLOCK_BYTES = 64;
    localparam int ROUNDS      = 64;
    localparam logic [7:0]  PAD_BYTE  = 8'h80;
    localparam logic [63:0] BLOCK_BITS = 64'd512;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUNDS,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } state_t;

    // block compression purpose
    typedef enum logic [1:0] {
        PASS_DATA,
        PASS_PAD_EXTRA,
        PASS_FINAL
    } pass_t;

    // controller to datapath commands
    typedef struct packed {
        logic       write_byte;
        logic [5:0] write_addr;
        logic [7:0] write_data;
        logic       add_block_bits;
        logic       latch_total;
        logic       load_work;
        logic       do_round;
        logic [5:0] round;
        logic       fold;
        logic       write_length;
        logic       restart;
        logic [2:0] emit_index;
    } ctrl_cmd_t;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        begin
            case (t)
                6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491;
                6'd2: k = 32'hb5c0fbcf; 6'd3: k = 32'he9b5dba5;
                6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5;
                6'd8: k = 32'hd807aa98; 6'd9: k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] h;
        begin
            case (i)
                3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
                3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
                3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
                3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
                default: h = 32'h0;
            endcase
            return h;
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/core/sha256_stream_hasher_unit.sv */
// ============================================================================
// sha256_stream_hasher_unit
// SHA-256 over a byte stream with a digest emitted on a finish item.
// ============================================================================
// Usage:
//   in channel (in_valid/in_stall/in_item): func 0 absorbs one message byte,
//   func 1 pads, appends the length, compresses and starts the digest.
//   out channel (out_valid/out_stall/out_item): eight 32-bit digest words,
//   index 0 first, last_word set on index 7.
// Sequence:
//   an absorb item writes one byte; the 64th byte of a block starts a compression
//   (64 rounds on the single round unit and one fold; the load of the
//   working registers happens in the accept cycle).
//   a finish item takes the zero padding fill (one byte a cycle, up to 63),
//   one or two compressions (load, 64 rounds, fold), then the eight
//   digest words, each held while out_stall is high.
// Reset loads the initial hash values and clears the bit count and fill
// count; the message restarts. While out_stall is high the current digest
// word holds and no input item is accepted until the eighth word is taken.
// ============================================================================
`default_nettype none

module sha256_stream_hasher_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire sha_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output sha_pkg::out_item_t      out_item
);

    sha_pkg::ctrl_cmd_t cmd;
    logic [31:0]        emit_word;

    sha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .emit_word (emit_word),
        .cmd       (cmd)
    );

    sha_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .emit_word (emit_word)
    );

endmodule

`default_nettype wire

/* rtl/core/sha_datapath.sv */
// ============================================================================
// sha_datapath
// Block buffer, message schedule, round registers, chain value and bit count.
// ============================================================================
`default_nettype none

module sha_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sha_pkg::ctrl_cmd_t cmd,
    output logic [31:0]            emit_word
);

    // block buffer as sixteen words, byte lanes written individually
    logic [31:0] blk_reg [16];
    logic [31:0] w_reg [16];
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [63:0] bitlen_reg;
    logic [63:0] total_reg;

    logic [31:0] w_new;
    logic [31:0] a2, a15, s0w, s1w;
    logic [31:0] s0, s1, ch, maj, t1, t2;
    logic [3:0]  t_lo;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // message schedule word for this round
    always_comb
    begin
        t_lo = cmd.round[3:0];
        a2   = w_reg[4'(t_lo - 4'd2)];
        a15  = w_reg[4'(t_lo - 4'd15)];
        s1w  = rotr(a2, 17) ^ rotr(a2, 19) ^ (a2 >> 10);
        s0w  = rotr(a15, 7) ^ rotr(a15, 18) ^ (a15 >> 3);
        if (cmd.round[5:4] == 2'd0)
        begin
            w_new = blk_reg[t_lo];
        end
        else
        begin
            w_new = s1w + w_reg[4'(t_lo - 4'd7)] + s0w + w_reg[t_lo];
        end
    end

    // round function
    always_comb
    begin
        s1  = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1  = v_reg[7] + s1 + ch + sha_pkg::round_k(cmd.round) + w_new;
        s0  = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2  = s0 + maj;
    end

    assign emit_word = h_reg[cmd.emit_index];

    // buffer, schedule and working variables
    always_ff @(posedge clk)
    begin
        if (cmd.write_byte)
        begin
            case (cmd.write_addr[1:0])
                2'd0: blk_reg[cmd.write_addr[5:2]][31:24] <= cmd.write_data;
                2'd1: blk_reg[cmd.write_addr[5:2]][23:16] <= cmd.write_data;
                2'd2: blk_reg[cmd.write_addr[5:2]][15:8]  <= cmd.write_data;
                default: blk_reg[cmd.write_addr[5:2]][7:0] <= cmd.write_data;
            endcase
        end
        if (cmd.write_length)
        begin
            blk_reg[14] <= total_reg[63:32];
            blk_reg[15] <= total_reg[31:0];
        end
        if (cmd.load_work)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        if (cmd.do_round)
        begin
            w_reg[t_lo] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        if (cmd.latch_total)
        begin
            total_reg <= bitlen_reg + {55'd0, cmd.write_addr, 3'd0};
        end
    end

    // chain value and bit count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha_pkg::init_h(3'(i));
            end
            bitlen_reg <= '0;
        end
        else
        begin
            if (cmd.restart)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= sha_pkg::init_h(3'(i));
                end
                bitlen_reg <= '0;
            end
            else
            begin
                if (cmd.fold)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                end
                if (cmd.add_block_bits)
                begin
                    bitlen_reg <= bitlen_reg + sha_pkg::BLOCK_BITS;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/sha_ctrl.sv */
// ============================================================================
// sha_ctrl
// Controller: byte intake, padding sequence, round count and digest output.
// ============================================================================
`default_nettype none

module sha_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire sha_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output sha_pkg::out_item_t      out_item,
    input  wire logic [31:0]        emit_word,
    output sha_pkg::ctrl_cmd_t      cmd
);

    sha_pkg::state_t state_reg, state_next;
    sha_pkg::pass_t  pass_reg, pass_next;
    logic [5:0] fill_reg, fill_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [2:0] idx_reg, idx_next;
    logic       accept;

    assign accept = in_valid && !in_stall;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha_pkg::ST_IDLE;
            pass_reg  <= sha_pkg::PASS_DATA;
            fill_reg  <= '0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            fill_reg  <= fill_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        fill_next  = fill_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.round      = cnt_reg;
        cmd.emit_index = idx_reg;
        cmd.write_addr = fill_reg;
        in_stall   = (state_reg != sha_pkg::ST_IDLE);
        out_valid  = 1'b0;
        out_item.digest_word = emit_word;
        out_item.word_index  = idx_reg;
        out_item.last_word   = (idx_reg == 3'd7);
        case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.write_byte = 1'b1;
                    cnt_next = '0;
                    if (in_item.func == sha_pkg::FUNC_ABSORB)
                    begin
                        cmd.write_data = in_item.data_byte;
                        fill_next = fill_reg + 6'd1;
                        if (fill_reg == 6'd63)
                        begin
                            pass_next  = sha_pkg::PASS_DATA;
                            state_next = sha_pkg::ST_ROUNDS;
                            cmd.load_work = 1'b1;
                        end
                    end
                    else
                    begin
                        // pad byte at current fill, then zeros
                        cmd.write_data  = sha_pkg::PAD_BYTE;
                        cmd.latch_total = 1'b1;
                        fill_next  = fill_reg + 6'd1;
                        pass_next  = (fill_reg >= 6'd56) ? sha_pkg::PASS_PAD_EXTRA
                                                         : sha_pkg::PASS_FINAL;
                        state_next = sha_pkg::ST_PAD;
                    end
                end
            end
            sha_pkg::ST_PAD:
            begin
                // zero fill one byte per cycle up to 56 or 64
                if ((pass_reg == sha_pkg::PASS_PAD_EXTRA && fill_reg == 6'd0) ||
                    (pass_reg == sha_pkg::PASS_FINAL && fill_reg >= 6'd56))
                begin
                    if (pass_reg == sha_pkg::PASS_FINAL)
                    begin
                        cmd.write_length = 1'b1;
                    end
                    cmd.load_work = 1'b1;
                    cnt_next   = '0;
                    state_next = sha_pkg::ST_ROUNDS;
                end
                else
                begin
                    cmd.write_byte = 1'b1;
                    cmd.write_data = '0;
                    fill_next = fill_reg + 6'd1;
                end
            end
            sha_pkg::ST_ROUNDS:
            begin
                cmd.do_round = 1'b1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(sha_pkg::ROUNDS - 1))
                begin
                    state_next = sha_pkg::ST_FOLD;
                end
            end
            sha_pkg::ST_FOLD:
            begin
                cmd.fold = 1'b1;
                case (pass_reg)
                    sha_pkg::PASS_DATA:
                    begin
                        cmd.add_block_bits = 1'b1;
                        state_next = sha_pkg::ST_IDLE;
                    end
                    sha_pkg::PASS_PAD_EXTRA:
                    begin
                        fill_next  = '0;
                        pass_next  = sha_pkg::PASS_FINAL;
                        state_next = sha_pkg::ST_PAD;
                    end
                    default:
                    begin
                        idx_next   = '0;
                        state_next = sha_pkg::ST_EMIT;
                    end
                endcase
            end
            sha_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        cmd.restart = 1'b1;
                        fill_next   = '0;
                        state_next  = sha_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sha_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/sha_checker.sv */
// ============================================================================
// sha_checker
// Port-level checks for the SHA-256 stream hasher.
// ============================================================================
`default_nettype none

module sha_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire sha_pkg::in_item_t  in_item,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire sha_pkg::out_item_t out_item
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled item changed");

    // no input taken while a digest is out
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted during digest");

    // last flag only on word seven
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.last_word == (out_item.word_index == 3'd7)))
        else $error("last_word mismatch");

    // words come in order
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_item.last_word |=>
        out_valid && out_item.word_index == $past(out_item.word_index) + 3'd1)
        else $error("word order broken");

endmodule

bind sha256_stream_hasher_unit sha_checker u_sha_checker (.*);

`default_nettype wire
